>>> rtl/core/rau_pkg.sv
// rational arithmetic unit package: operation codes
// no dependencies
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_RECIP = 3'd4,
        OP_NORM  = 3'd5,
        OP_EQ    = 3'd6,
        OP_NONE  = 3'd7
    } t_op;

endpackage

>>> rtl/core/rational_arithmetic_unit_core.sv
// rational arithmetic unit top level: one multiplier and one radix-2 divider
// shared under a sequencer; depends on rau_pkg
//
// A transaction is taken when start is high and busy is low; busy stays high
// until the single result is shown for one cycle with o_done. The receiver
// cannot stall. The bit-serial divider holds the sequencer for each remainder
// or quotient, and every Euclid step also passes through a zero check. A
// reduction pass runs Euclid and then two quotients; arithmetic operations
// and OP_RECIP run two passes, OP_NORM runs one, and an unused code goes
// straight to the result.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_op,
    input  logic signed [31:0]  i_a_num,
    input  logic signed [31:0]  i_a_den,
    input  logic signed [31:0]  i_b_num,
    input  logic signed [31:0]  i_b_den,
    output logic                o_done,
    output logic signed [31:0]  o_res_num,
    output logic signed [31:0]  o_res_den,
    output logic                o_is_equal
);

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE  = W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_VAL, S_GCHK, S_GDIV,
        S_QN, S_QD, S_EQA, S_EQB, S_DONE
    } t_state;

    t_state         r_state;
    t_op            r_op;
    logic [W-1:0]   r_an, r_ad, r_bn, r_bd;
    logic [W-1:0]   r_n, r_d, r_x, r_y, r_g, r_t;
    logic [1:0]     r_pass;
    logic           r_eq;

    // shared multiplier
    logic [W-1:0]   mul_a, mul_b, mul_p;
    logic [2*W-1:0] mul_full;

    // shared bit-serial divider on magnitudes
    logic           r_dv_run;
    logic [CW-1:0]  r_dv_cnt;
    logic [W-1:0]   r_dv_q, r_dv_r, r_dv_b;
    logic           r_dv_qneg, r_dv_rneg;
    logic           dv_start;
    logic [W-1:0]   dv_a, dv_b;
    logic [W:0]     dv_trial;
    logic [W-1:0]   dv_shift;
    logic           dv_fin;
    logic [W-1:0]   dv_quo, dv_rem;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] x);
        f_mag = x[W-1] ? (~x + ONE) : x;
    endfunction

    function automatic logic [W-1:0] f_ext(input logic [31:0] x);
        logic [63:0] t;
        t = {{32{x[31]}}, x};
        f_ext = t[W-1:0];
    endfunction

    function automatic logic [31:0] f_out(input logic [W-1:0] x);
        logic [63:0] t;
        t = {{(64-W){x[W-1]}}, x};
        f_out = t[31:0];
    endfunction

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[W-1:0];

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        unique case (r_state)
            S_M0:    begin mul_a = r_an; mul_b = (r_op == OP_MUL) ? r_bn : r_bd; end
            S_M1:    begin mul_a = r_ad; mul_b = (r_op == OP_DIV) ? r_bn : r_bd; end
            S_M2:    begin mul_a = r_bn; mul_b = r_ad; end
            default: begin mul_a = r_an; mul_b = r_bd; end
        endcase
    end

    // divider step: shift remainder left with next dividend bit
    assign dv_shift = {r_dv_r[W-2:0], r_dv_q[W-1]};
    assign dv_trial = {r_dv_r, r_dv_q[W-1]} - {1'b0, r_dv_b};
    assign dv_fin   = r_dv_run && (r_dv_cnt == CW'(W));
    assign dv_quo   = r_dv_qneg ? (~r_dv_q + ONE) : r_dv_q;
    assign dv_rem   = r_dv_rneg ? (~r_dv_r + ONE) : r_dv_r;

    always_comb begin
        dv_start = 1'b0;
        dv_a     = r_x;
        dv_b     = r_y;
        if (!r_dv_run) begin
            unique case (r_state)
                S_GDIV:  begin dv_start = 1'b1; dv_a = r_x; dv_b = r_y; end
                S_QN:    begin dv_start = 1'b1; dv_a = r_n; dv_b = r_g; end
                S_QD:    begin dv_start = 1'b1; dv_a = r_d; dv_b = r_g; end
                // wait until both denominators are validated
                S_EQA:   begin
                    dv_start = (r_ad != '0) && (r_bd != '0);
                    dv_a = r_an;
                    dv_b = r_ad;
                end
                S_EQB:   begin dv_start = 1'b1; dv_a = r_bn; dv_b = r_bd; end
                default: begin dv_start = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_run <= 1'b0;
            r_dv_cnt <= '0;
        end else if (dv_start) begin
            r_dv_run  <= 1'b1;
            r_dv_cnt  <= '0;
            r_dv_q    <= f_mag(dv_a);
            r_dv_r    <= '0;
            r_dv_b    <= f_mag(dv_b);
            r_dv_qneg <= dv_a[W-1] ^ dv_b[W-1];
            r_dv_rneg <= dv_a[W-1];
        end else if (r_dv_run) begin
            if (dv_fin) begin
                r_dv_run <= 1'b0;
            end else begin
                r_dv_cnt <= r_dv_cnt + CW'(1);
                if (!dv_trial[W] && (r_dv_b != '0)) begin
                    r_dv_r <= dv_trial[W-1:0];
                    r_dv_q <= {r_dv_q[W-2:0], 1'b1};
                end else begin
                    r_dv_r <= (r_dv_b != '0) ? dv_shift : '0;
                    r_dv_q <= {r_dv_q[W-2:0], 1'b0};
                end
            end
        end
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_done     <= 1'b0;
            o_is_equal <= 1'b0;
        end else begin
            o_done <= (r_state == S_DONE);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op <= t_op'(i_op);
                        r_an <= f_ext(i_a_num);
                        r_ad <= f_ext(i_a_den);
                        r_bn <= f_ext(i_b_num);
                        r_bd <= f_ext(i_b_den);
                        r_pass <= (t_op'(i_op) == OP_NORM) ? 2'd1 : 2'd2;
                        r_eq <= 1'b0;
                        unique case (t_op'(i_op))
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: r_state <= S_M0;
                            OP_RECIP: begin
                                r_n <= f_ext(i_a_den);
                                r_d <= f_ext(i_a_num);
                                r_state <= S_VAL;
                            end
                            OP_NORM: begin
                                r_n <= f_ext(i_a_num);
                                r_d <= f_ext(i_a_den);
                                r_state <= S_VAL;
                            end
                            OP_EQ: r_state <= S_EQA;
                            default: begin
                                r_n <= '0;
                                r_d <= ONE;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_M0: begin
                    r_t <= mul_p;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_d <= mul_p;
                    if (r_op == OP_MUL || r_op == OP_DIV) begin
                        r_n <= r_t;
                        r_state <= S_VAL;
                    end else begin
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    r_n <= (r_op == OP_SUB) ? (r_t - mul_p) : (r_t + mul_p);
                    r_state <= S_VAL;
                end
                S_M3: r_state <= S_VAL;
                S_VAL: begin
                    if (r_d == '0) begin
                        r_n <= WMAX;
                        r_d <= ONE;
                        r_x <= WMAX;
                        r_y <= ONE;
                    end else begin
                        r_x <= r_n;
                        r_y <= r_d;
                    end
                    r_state <= S_GCHK;
                end
                S_GCHK: begin
                    if (r_x == '0) begin
                        r_g <= r_y;
                        r_state <= S_QN;
                    end else if (r_y == '0) begin
                        r_g <= r_x;
                        r_state <= S_QN;
                    end else begin
                        r_state <= S_GDIV;
                    end
                end
                S_GDIV: begin
                    if (dv_fin) begin
                        r_x <= r_y;
                        r_y <= dv_rem;
                        r_state <= S_GCHK;
                    end
                end
                S_QN: begin
                    if (dv_fin) begin
                        r_t <= dv_quo;
                        r_state <= S_QD;
                    end
                end
                S_QD: begin
                    if (dv_fin) begin
                        r_n <= r_t;
                        r_d <= dv_quo;
                        if (r_pass == 2'd2) begin
                            r_pass <= 2'd1;
                            r_state <= S_VAL;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_EQA: begin
                    if (r_ad == '0) begin
                        r_an <= WMAX;
                        r_ad <= ONE;
                    end else if (r_bd == '0) begin
                        r_bn <= WMAX;
                        r_bd <= ONE;
                    end else if (dv_fin) begin
                        r_t <= dv_quo;
                        r_state <= S_EQB;
                    end
                end
                S_EQB: begin
                    if (dv_fin) begin
                        r_eq <= (dv_quo == r_t);
                        r_n <= '0;
                        r_d <= ONE;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_res_num  <= f_out(r_n);
                    o_res_den  <= f_out(r_d);
                    o_is_equal <= r_eq;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/rau_checker.sv
// port-level checks for the rational arithmetic unit
// depends on rational_arithmetic_unit_core ports only
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_res_den,
    input logic        o_is_equal
);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transaction not taken");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result repeated");

    a_eq_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_equal) |-> (o_res_den == 32'd1))
        else $error("equal result without unit denominator");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_res_den  (o_res_den),
    .o_is_equal (o_is_equal)
);
